[rtl/bdq_pkg.sv]
// Package for the bounded deque with dump.
// Holds widths, command and status codes, controller states and the cell op struct.
// No dependencies.
package bdq_pkg;

    localparam int BDQ_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PUSH_REAR  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_DUMPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_DUMP
    } state_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_rear;
        logic rotate;
    } cell_op_t;

endpackage

[rtl/bdq_cmd_if.sv]
// Command channel: valid/ready handshake carrying one command word.
// Depends on bdq_pkg.
interface bdq_cmd_if
    import bdq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

[rtl/bdq_res_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on bdq_pkg.
interface bdq_res_if
    import bdq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

[rtl/bounded_deque_with_dump_core.sv]
// Top level of the bounded deque with dump: a chain of element cells plus controller.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if, bdq_cell, bdq_ctrl.
//
//   channel | direction | word
//   cmd     | in        | command[2:0], value[31:0] signed
//   res     | out       | data[31:0] signed, status[2:0], last
//
// Push front/rear and pop front complete on acceptance. Pop rear: accept, the chain
// rotates count-1 places, then pops the head. Dump: the accept, then one word per
// cycle while the result side is not stalled.
// Reset clears the cell valid flags and the controller at once; no clearing pass.
// A stalled result holds the controller, though the rotate steps of a pop rear still run;
// the result register lets the next command in as the current word is taken.
module bounded_deque_with_dump_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_res_if.source res
);

    cell_op_t                 op;
    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic                     cell_valid [DEPTH];

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .head_data (cell_data[0]),
        .op        (op)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic                     left_valid;
        logic signed [DATA_W-1:0] right_data;
        logic                     right_valid;

        if (i == 0)
        begin : g_head
            assign left_data  = cmd.value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        bdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .value       (cmd.value),
            .head_data   (cell_data[0]),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i])
        );
    end

endmodule

[rtl/bdq_cell.sv]
// One storage cell of the deque chain: an element and its valid flag.
// Depends on bdq_pkg; instantiated in a row by the top level.
module bdq_cell
    import bdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_op_t                 op,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] head_data,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic                     left_valid,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic                     right_valid,
    output logic signed [DATA_W-1:0] data,
    output logic                     valid
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     is_rear;

    assign is_rear = valid_reg && !right_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.push_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (op.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (op.push_rear)
        begin
            if (!valid_reg && left_valid)
            begin
                data_next  = value;
                valid_next = 1'b1;
            end
        end
        else if (op.rotate && valid_reg)
        begin
            // rear cell wraps the head element around
            data_next = is_rear ? head_data : right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

[rtl/bdq_ctrl.sv]
// Deque controller: command decode, element count, rotate/dump sequencing, result register.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if; drives the op of the cell chain.
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    bdq_cmd_if.sink                  cmd,
    bdq_res_if.source                res,
    input  logic signed [DATA_W-1:0] head_data,
    output cell_op_t                 op
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    status_t                  out_status_reg, out_status_next;
    logic                     out_last_reg, out_last_next;
    logic                     load;
    logic                     out_free;
    logic                     full;
    logic                     empty;
    cmd_t                     command;

    assign out_free = !out_valid_reg || res.ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign command  = cmd_t'(cmd.command);

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && out_free)
                begin
                    case (command)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                            if (!full)
                                count_next = count_reg + 1'b1;
                        CMD_POP_FRONT:
                            if (!empty)
                                count_next = count_reg - 1'b1;
                        CMD_POP_REAR:
                            if (!empty)
                            begin
                                state_next = S_ROTATE;
                                step_next  = count_reg - 1'b1;
                            end
                        CMD_DUMP:
                            if (!empty)
                            begin
                                state_next = S_DUMP;
                                step_next  = count_reg;
                            end
                        default: ;
                    endcase
                end
            end
            S_ROTATE:
            begin
                if (step_reg != '0)
                    step_next = step_reg - 1'b1;
                else if (out_free)
                begin
                    state_next = S_IDLE;
                    count_next = count_reg - 1'b1;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    step_next = step_reg - 1'b1;
                    if (step_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op              = '0;
        load            = 1'b0;
        out_data_next   = '0;
        out_status_next = ST_PUSHED;
        out_last_next   = 1'b1;
        cmd.ready       = (state_reg == S_IDLE) && out_free;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && out_free)
                begin
                    case (command)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                        begin
                            load = 1'b1;
                            if (full)
                                out_status_next = ST_FULL;
                            else
                            begin
                                out_status_next = ST_PUSHED;
                                op.push_front   = (command == CMD_PUSH_FRONT);
                                op.push_rear    = (command == CMD_PUSH_REAR);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            load = 1'b1;
                            if (empty)
                                out_status_next = ST_EMPTY;
                            else
                            begin
                                out_status_next = ST_POPPED;
                                out_data_next   = head_data;
                                op.pop_front    = 1'b1;
                            end
                        end
                        CMD_POP_REAR, CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                load            = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ROTATE:
            begin
                // rear element is brought to the head, then popped from the front
                if (step_reg != '0)
                    op.rotate = 1'b1;
                else if (out_free)
                begin
                    load            = 1'b1;
                    out_data_next   = head_data;
                    out_status_next = ST_POPPED;
                    op.pop_front    = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_data_next   = head_data;
                    out_status_next = ST_DUMPED;
                    out_last_next   = (step_reg == CNT_W'(1));
                    op.rotate       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.data   = out_data_reg;
    assign res.status = out_status_reg;
    assign res.last   = out_last_reg;

endmodule

[rtl/bdq_checker.sv]
// Port-level checks for the bounded deque with dump, bound to the top level.
// Depends on bdq_pkg.
module bdq_checker
    import bdq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cmd_valid,
    input logic                     cmd_ready,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic signed [DATA_W-1:0] res_data,
    input logic [STATUS_W-1:0]      res_status,
    input logic                     res_last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data)
            && $stable(res_status) && $stable(res_last))
        else $error("result word changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_PUSHED || res_status == ST_POPPED
            || res_status == ST_EMPTY || res_status == ST_FULL) |-> res_last)
        else $error("single result word without last");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_PUSHED || res_status == ST_EMPTY
            || res_status == ST_FULL) |-> res_data == '0)
        else $error("status word carries nonzero data");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> !(res_valid && !res_ready))
        else $error("command taken while result slot blocked");

endmodule

bind bounded_deque_with_dump_core bdq_checker u_bdq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_data   (res.data),
    .res_status (res.status),
    .res_last   (res.last)
);

[tb/bounded_deque_with_dump_core_test.sv]
// Testbench for bounded_deque_with_dump_core: drives deque commands, mirrors the deque
// in a ring-buffer scoreboard class and checks every result word in order.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if and the core RTL.
`timescale 1ns / 100ps

module bounded_deque_with_dump_core_test
    import bdq_pkg::*;
();

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int IDLE_MAX      = 12;
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AT       = 150;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_WORDS  = 480;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic                     last;
    } result_word_t;

    class deque_mirror;
        logic signed [DATA_W-1:0] slots [BDQ_DEPTH];
        int                       head;
        int                       fill;
        result_word_t             pending [$];
        int                       mismatches;

        function new();
            head       = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function void expect_word(logic signed [DATA_W-1:0] d, status_t s, logic l);
            result_word_t w;
            w.data   = d;
            w.status = s;
            w.last   = l;
            pending.push_back(w);
        endfunction

        function void note_command(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
            case (c)
                CMD_PUSH_FRONT, CMD_PUSH_REAR:
                begin
                    if (fill >= BDQ_DEPTH)
                        expect_word('0, ST_FULL, 1'b1);
                    else
                    begin
                        if (c == CMD_PUSH_FRONT)
                        begin
                            head = (head + BDQ_DEPTH - 1) % BDQ_DEPTH;
                            slots[head] = v;
                        end
                        else
                            slots[(head + fill) % BDQ_DEPTH] = v;
                        fill++;
                        expect_word('0, ST_PUSHED, 1'b1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (fill == 0)
                        expect_word('0, ST_EMPTY, 1'b1);
                    else
                    begin
                        expect_word(slots[head], ST_POPPED, 1'b1);
                        head = (head + 1) % BDQ_DEPTH;
                        fill--;
                    end
                end
                CMD_POP_REAR:
                begin
                    if (fill == 0)
                        expect_word('0, ST_EMPTY, 1'b1);
                    else
                    begin
                        expect_word(slots[(head + fill - 1) % BDQ_DEPTH], ST_POPPED, 1'b1);
                        fill--;
                    end
                end
                CMD_DUMP:
                begin
                    if (fill == 0)
                        expect_word('0, ST_EMPTY, 1'b1);
                    else
                        for (int i = 0; i < fill; i++)
                            expect_word(slots[(head + i) % BDQ_DEPTH], ST_DUMPED,
                                        (i + 1 == fill));
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_result(logic signed [DATA_W-1:0] d, logic [STATUS_W-1:0] s, logic l);
            result_word_t w;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word data=%0d status=%0d last=%0b",
                                          d, s, l));
                return;
            end
            w = pending.pop_front();
            if (d !== w.data)
                report_mismatch($sformatf("data %0d, want %0d", d, w.data));
            if (s !== w.status)
                report_mismatch($sformatf("status %0d, want %0d", s, w.status));
            if (l !== w.last)
                report_mismatch($sformatf("last %0b, want %0b", l, w.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bdq_cmd_if cmd_ch ();
    bdq_res_if res_ch ();

    bounded_deque_with_dump_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    deque_mirror board = new();
    int          quiet_cycles = 0;
    int          words_taken = 0;
    bit          tx_idle;
    bit          rx_idle;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bounded_deque_with_dump_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Valid stays high into the next word unless an idle gap is drawn.
    task automatic send_word(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        int gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.value   <= v;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        board.note_command(c, v);
    endtask

    task automatic take_word();
        int gap;
        gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            res_ch.ready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        do
            @(posedge clk);
        while (!res_ch.valid);
        board.check_result(res_ch.data, res_ch.status, res_ch.last);
        words_taken++;
    endtask

    task automatic run_directed();
        send_word(CMD_DUMP, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_PUSH_FRONT, 32'sh7fffffff);
        send_word(CMD_PUSH_REAR, 32'sh80000000);
        send_word(CMD_PUSH_FRONT, '0);
        send_word(CMD_PUSH_REAR, -32'sd1);
        send_word(CMD_DUMP, $urandom);
        send_word(CMD_SPARE_LO, $urandom);
        send_word(CMD_SPARE_LO + 3'd1, $urandom);
        send_word(CMD_SPARE_HI, $urandom);
        send_word(CMD_POP_REAR, $urandom);
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_REAR, $urandom);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_PUSH_REAR, 32'sh55555555);
        send_word(CMD_PUSH_FRONT, 32'shaaaaaaaa);
        send_word(CMD_DUMP, '0);
        send_word(CMD_POP_REAR, '0);
        send_word(CMD_POP_REAR, '0);
    endtask

    // Phases lean toward filling, draining or mixing so that full and empty both recur.
    task automatic run_random();
        int                       sent;
        int                       push_pct;
        int                       roll;
        logic [CMD_W-1:0]         c;
        logic signed [DATA_W-1:0] v;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(30, 90))
            begin
                roll = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = -32'sd1;
                    3: v = '0;
                    default: v = $urandom;
                endcase
                if (roll < 2)
                    c = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                else if (roll < 8)
                    c = CMD_DUMP;
                else if ($urandom_range(0, 99) < push_pct)
                    c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
                else
                    c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
                send_word(c, v);
                if (c < CMD_SPARE_LO)
                    sent++;
                if (sent >= RANDOM_WORDS)
                    break;
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_PUSH_FRONT;
        cmd_ch.value   <= '0;
        tx_idle        = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        cmd_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("bounded_deque_with_dump_core verification clean");
        else
            $display("bounded_deque_with_dump_core verification failed");
        $finish;
    end

    // Result side: random stalls, unstalled stretches, and one long hold to back up the core.
    initial
    begin
        bit held;
        held         = 1'b0;
        rx_idle      = 1'b1;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && words_taken >= HOLD_AT)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (words_taken % 60 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            take_word();
        end
    end

endmodule

[filelist.f]
rtl/bdq_pkg.sv
rtl/bdq_cmd_if.sv
rtl/bdq_res_if.sv
rtl/bdq_cell.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_dump_core.sv
rtl/bdq_checker.sv
tb/bounded_deque_with_dump_core_test.sv
